// ===== rtl/cwbc_pkg.sv =====
// Shared opcodes, result kinds and sequencer states for the clock write-back cache.
`default_nettype none
package cwbc_pkg;
	localparam logic [1:0] OP_GET   = 2'd0;
	localparam logic [1:0] OP_SET   = 2'd1;
	localparam logic [1:0] OP_FILL  = 2'd2;
	localparam logic [1:0] OP_FLUSH = 2'd3;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_WB     = 1'b1;

	localparam logic ST_HIT  = 1'b0;
	localparam logic ST_MISS = 1'b1;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SRCH   = 4'd1;
	localparam logic [3:0] S_SCMP   = 4'd2;
	localparam logic [3:0] S_DECIDE = 4'd3;
	localparam logic [3:0] S_SWEEP  = 4'd4;
	localparam logic [3:0] S_VRD    = 4'd5;
	localparam logic [3:0] S_VOUT   = 4'd6;
	localparam logic [3:0] S_WRITE  = 4'd7;
	localparam logic [3:0] S_STAT   = 4'd8;
	localparam logic [3:0] S_FLRD   = 4'd9;
	localparam logic [3:0] S_FLOUT  = 4'd10;
	localparam logic [3:0] S_HITRD  = 4'd11;
	localparam logic [3:0] S_WAIT   = 4'd12;
endpackage
`default_nettype wire

// ===== rtl/clock_writeback_cache_core.sv =====
// Top level: fully associative write-back cache with clock replacement.
// Throughput: one item at a time; in_stall stays high until the sequencer is back in idle.
// Reset clears control, reference/dirty bits, fill count and hand; key/value memories are
// not cleared (only slots below the fill count are ever read).
`default_nettype none
module clock_writeback_cache_core #(
	parameter int CAPACITY   = 16,
	parameter int KEY_BITS   = 64,
	parameter int VALUE_BITS = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [1:0]            opcode,
	input  wire logic [KEY_BITS-1:0]   key_tag,
	input  wire logic [VALUE_BITS-1:0] value_in,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       kind,
	output logic                       status,
	output logic [KEY_BITS-1:0]        key_out,
	output logic [VALUE_BITS-1:0]      value_out,
	output logic                       last,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [4:0]            cfg_data
);
	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	// key and value memories, registered read
	logic [KEY_BITS-1:0]   kmem [CAPACITY];
	logic [VALUE_BITS-1:0] vmem [CAPACITY];
	logic [CAPACITY-1:0]   ref_q, mod_q;
	logic [CW-1:0]         fill_q;
	logic [IW-1:0]         hand_q;
	logic [4:0]            eiu_q;

	logic [3:0]            st_q;
	logic [1:0]            op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [CW-1:0]         idx_q;     // search / flush counter
	logic [IW-1:0]         slot_q;
	logic                  hit_q;
	logic [CW:0]           guard_q;

	logic                  rd_en, k_we, v_we;
	logic [IW-1:0]         rd_addr, wr_addr;
	logic [KEY_BITS-1:0]   kq;
	logic [VALUE_BITS-1:0] vq;

	logic                  ov_q, okind_q, ostat_q, olast_q;
	logic [KEY_BITS-1:0]   okey_q;
	logic [VALUE_BITS-1:0] oval_q;

	// effective capacity, clamped to 1..CAPACITY
	logic [CW-1:0] cap;
	always_comb begin
		if (eiu_q == 5'd0) cap = CW'(1);
		else if ({1'b0, eiu_q} > 6'(CAPACITY)) cap = CAP_C;
		else cap = CW'(eiu_q);
	end

	wire logic out_free = !ov_q || !out_stall;
	// output register takes a new transfer this cycle
	logic out_load;
	assign out_load = out_free && (st_q == cwbc_pkg::S_VOUT || st_q == cwbc_pkg::S_FLOUT
		|| st_q == cwbc_pkg::S_STAT);
	logic [IW-1:0] hand_n;
	assign hand_n = ({1'b0, hand_q} + 1'b1 >= {1'b0, cap}) ? '0 : hand_q + 1'b1;

	assign in_stall  = (st_q != cwbc_pkg::S_IDLE);
	// capacity changes only between items, never on the edge an item is taken
	assign cfg_ready = (st_q == cwbc_pkg::S_IDLE) && !in_valid;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			kq <= kmem[rd_addr];
			vq <= vmem[rd_addr];
		end
		if (k_we) kmem[wr_addr] <= key_q;
		if (v_we) vmem[wr_addr] <= val_q;
	end

	always_comb begin
		rd_en = 1'b0; rd_addr = idx_q[IW-1:0];
		k_we = 1'b0; v_we = 1'b0; wr_addr = slot_q;
		case (st_q)
			cwbc_pkg::S_SRCH, cwbc_pkg::S_FLRD: rd_en = 1'b1;
			cwbc_pkg::S_VRD, cwbc_pkg::S_HITRD: begin
				rd_en = 1'b1; rd_addr = slot_q;
			end
			cwbc_pkg::S_WRITE: begin
				k_we = !hit_q;
				v_we = (op_q == cwbc_pkg::OP_SET) || !hit_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= cwbc_pkg::S_IDLE; ref_q <= '0; mod_q <= '0; fill_q <= '0;
			hand_q <= '0; eiu_q <= 5'd16; ov_q <= 1'b0;
		end else begin
			if (ov_q && !out_stall && !out_load) ov_q <= 1'b0;
			if (cfg_valid && cfg_ready) eiu_q <= cfg_data;
			case (st_q)
				cwbc_pkg::S_IDLE: if (in_valid) begin
					op_q <= opcode; key_q <= key_tag; val_q <= value_in;
					idx_q <= '0; hit_q <= 1'b0;
					st_q <= (opcode == cwbc_pkg::OP_FLUSH) ? cwbc_pkg::S_FLRD
						: cwbc_pkg::S_SRCH;
				end
				cwbc_pkg::S_SRCH: begin
					if (idx_q >= fill_q) st_q <= cwbc_pkg::S_DECIDE;
					else st_q <= cwbc_pkg::S_SCMP;
				end
				cwbc_pkg::S_SCMP: begin
					if (kq == key_q) begin
						hit_q <= 1'b1; slot_q <= idx_q[IW-1:0];
						st_q <= cwbc_pkg::S_DECIDE;
					end else begin
						idx_q <= idx_q + 1'b1; st_q <= cwbc_pkg::S_SRCH;
					end
				end
				cwbc_pkg::S_DECIDE: begin
					guard_q <= '0;
					if (hit_q) begin
						st_q <= (op_q == cwbc_pkg::OP_SET) ? cwbc_pkg::S_WRITE
							: cwbc_pkg::S_HITRD;
					end else if (op_q == cwbc_pkg::OP_GET) begin
						st_q <= cwbc_pkg::S_STAT;
					end else if (fill_q < cap) begin
						slot_q <= fill_q[IW-1:0]; fill_q <= fill_q + 1'b1;
						st_q <= cwbc_pkg::S_WRITE;
					end else begin
						if ({1'b0, hand_q} >= cap) hand_q <= '0;
						st_q <= cwbc_pkg::S_SWEEP;
					end
				end
				cwbc_pkg::S_SWEEP: begin
					if (!ref_q[hand_q] || guard_q >= {cap, 1'b0}) begin
						slot_q <= hand_q; hand_q <= hand_n;
						st_q <= mod_q[hand_q] ? cwbc_pkg::S_VRD : cwbc_pkg::S_WRITE;
					end else begin
						ref_q[hand_q] <= 1'b0; hand_q <= hand_n;
						guard_q <= guard_q + 1'b1;
					end
				end
				cwbc_pkg::S_VRD: st_q <= cwbc_pkg::S_VOUT;
				cwbc_pkg::S_VOUT: if (out_free) begin
					ov_q <= 1'b1; okind_q <= cwbc_pkg::KIND_WB;
					ostat_q <= cwbc_pkg::ST_HIT; okey_q <= kq; oval_q <= vq;
					olast_q <= 1'b0; st_q <= cwbc_pkg::S_WRITE;
				end
				cwbc_pkg::S_HITRD: begin
					ref_q[slot_q] <= 1'b1; st_q <= cwbc_pkg::S_WAIT;
				end
				cwbc_pkg::S_WAIT: begin
					val_q <= vq; st_q <= cwbc_pkg::S_STAT;
				end
				cwbc_pkg::S_WRITE: begin
					ref_q[slot_q] <= 1'b1;
					if (op_q == cwbc_pkg::OP_SET) mod_q[slot_q] <= 1'b1;
					else mod_q[slot_q] <= 1'b0;
					st_q <= cwbc_pkg::S_STAT;
				end
				cwbc_pkg::S_FLRD: begin
					if (idx_q >= fill_q) st_q <= cwbc_pkg::S_STAT;
					else begin
						ref_q[idx_q[IW-1:0]] <= 1'b0;
						st_q <= mod_q[idx_q[IW-1:0]] ? cwbc_pkg::S_FLOUT
							: cwbc_pkg::S_FLRD;
						if (!mod_q[idx_q[IW-1:0]]) idx_q <= idx_q + 1'b1;
					end
				end
				cwbc_pkg::S_FLOUT: if (out_free) begin
					ov_q <= 1'b1; okind_q <= cwbc_pkg::KIND_WB;
					ostat_q <= cwbc_pkg::ST_HIT; okey_q <= kq; oval_q <= vq;
					olast_q <= 1'b0; mod_q[idx_q[IW-1:0]] <= 1'b0;
					idx_q <= idx_q + 1'b1; st_q <= cwbc_pkg::S_FLRD;
				end
				cwbc_pkg::S_STAT: if (out_free) begin
					ov_q <= 1'b1; okind_q <= cwbc_pkg::KIND_STATUS;
					okey_q <= key_q; olast_q <= 1'b1;
					ostat_q <= (op_q == cwbc_pkg::OP_GET && !hit_q) ? cwbc_pkg::ST_MISS
						: cwbc_pkg::ST_HIT;
					oval_q <= ((op_q == cwbc_pkg::OP_GET && !hit_q)
						|| op_q == cwbc_pkg::OP_FLUSH) ? '0 : val_q;
					st_q <= cwbc_pkg::S_IDLE;
				end
				default: st_q <= cwbc_pkg::S_IDLE;
			endcase
		end
	end

	assign out_valid = ov_q;
	assign kind      = okind_q;
	assign status    = ostat_q;
	assign key_out   = okey_q;
	assign value_out = oval_q;
	assign last      = olast_q;
endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the clock write-back cache core.
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// One expected result of the cache.
	typedef struct packed {
		logic        kind;
		logic        status;
		logic [63:0] key;
		logic [63:0] value;
		logic        last;
	} cache_result_t;

	int unsigned mismatch_count = 0;

	// Prints one line per mismatch and counts it.
	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatch_count++;
		$display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
	endtask

	// Scoreboard: a copy of the cache state and the queue of results it predicts.
	class cache_scoreboard;
		logic [63:0]   keys [16];
		logic [63:0]   values [16];
		bit            ref_bit [16];
		bit            dirty [16];
		int unsigned   filled;
		int unsigned   hand;
		int unsigned   capacity_reg;
		cache_result_t pending [$];

		function new();
			filled = 0;
			hand = 0;
			capacity_reg = 16;
			foreach (ref_bit[i]) begin
				ref_bit[i] = 0;
				dirty[i] = 0;
			end
		endfunction

		function int unsigned live_capacity();
			if (capacity_reg < 1)
				return 1;
			if (capacity_reg > 16)
				return 16;
			return capacity_reg;
		endfunction

		function int find_slot(logic [63:0] key);
			for (int i = 0; i < filled; i++)
				if (keys[i] == key)
					return i;
			return -1;
		endfunction

		function void push(logic k, logic s, logic [63:0] key, logic [63:0] v, logic l);
			cache_result_t r;
			r.kind = k;
			r.status = s;
			r.key = key;
			r.value = v;
			r.last = l;
			pending.push_back(r);
		endfunction

		// Free slot or clock victim; a dirty victim is written back.
		function int unsigned claim_slot();
			int unsigned cap;
			int unsigned slot;
			cap = live_capacity();
			if (filled < cap) begin
				slot = filled;
				filled++;
				return slot;
			end
			if (hand >= cap)
				hand = 0;
			for (int g = 0; g < 2 * cap; g++) begin
				if (!ref_bit[hand])
					break;
				ref_bit[hand] = 0;
				hand = (hand + 1) % cap;
			end
			slot = hand;
			if (dirty[slot])
				push(cwbc_pkg::KIND_WB, cwbc_pkg::ST_HIT, keys[slot], values[slot], 1'b0);
			hand = (hand + 1) % cap;
			return slot;
		endfunction

		function void note_request(logic [1:0] op, logic [63:0] key, logic [63:0] v);
			int hit;
			int unsigned slot;
			hit = find_slot(key);
			case (op)
				cwbc_pkg::OP_GET: begin
					if (hit >= 0) begin
						ref_bit[hit] = 1;
						push(cwbc_pkg::KIND_STATUS, cwbc_pkg::ST_HIT, key, values[hit], 1'b1);
					end else
						push(cwbc_pkg::KIND_STATUS, cwbc_pkg::ST_MISS, key, 64'd0, 1'b1);
				end
				cwbc_pkg::OP_SET: begin
					if (hit >= 0)
						slot = hit;
					else begin
						slot = claim_slot();
						keys[slot] = key;
					end
					values[slot] = v;
					ref_bit[slot] = 1;
					dirty[slot] = 1;
					push(cwbc_pkg::KIND_STATUS, cwbc_pkg::ST_HIT, key, v, 1'b1);
				end
				cwbc_pkg::OP_FILL: begin
					if (hit >= 0) begin
						ref_bit[hit] = 1;
						push(cwbc_pkg::KIND_STATUS, cwbc_pkg::ST_HIT, key, values[hit], 1'b1);
					end else begin
						slot = claim_slot();
						keys[slot] = key;
						values[slot] = v;
						ref_bit[slot] = 1;
						dirty[slot] = 0;
						push(cwbc_pkg::KIND_STATUS, cwbc_pkg::ST_HIT, key, v, 1'b1);
					end
				end
				default: begin
					for (int i = 0; i < filled; i++) begin
						if (dirty[i]) begin
							push(cwbc_pkg::KIND_WB, cwbc_pkg::ST_HIT, keys[i], values[i], 1'b0);
							dirty[i] = 0;
						end
						ref_bit[i] = 0;
					end
					push(cwbc_pkg::KIND_STATUS, cwbc_pkg::ST_HIT, key, 64'd0, 1'b1);
				end
			endcase
		endfunction

		task check_result(cache_result_t got);
			cache_result_t want;
			if (pending.size() == 0) begin
				report_mismatch("unexpected result key", got.key, 64'd0);
				return;
			end
			want = pending.pop_front();
			if (got.kind !== want.kind)
				report_mismatch("kind", 64'(got.kind), 64'(want.kind));
			if (got.status !== want.status)
				report_mismatch("status", 64'(got.status), 64'(want.status));
			if (got.key !== want.key)
				report_mismatch("key_out", got.key, want.key);
			if (got.value !== want.value)
				report_mismatch("value_out", got.value, want.value);
			if (got.last !== want.last)
				report_mismatch("last", 64'(got.last), 64'(want.last));
		endtask
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [1:0]  opcode = cwbc_pkg::OP_GET;
	logic [63:0] key_tag = '0;
	logic [63:0] value_in = '0;
	logic        out_valid;
	logic        out_stall = 0;
	logic        kind, status, last;
	logic [63:0] key_out, value_out;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [4:0]  cfg_data = '0;

	cache_scoreboard cache_model = new();

	// Receiver hold-off control: when nonzero, the stall process keeps stall high this long.
	int unsigned hold_off_cycles = 0;
	bit          random_stall = 0;

	always #2 clk = ~clk;

	clock_writeback_cache_core #(
		.CAPACITY(16),
		.KEY_BITS(64),
		.VALUE_BITS(64)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.key_tag(key_tag),
		.value_in(value_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.status(status),
		.key_out(key_out),
		.value_out(value_out),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// Results are checked at the rising edge on which they transfer.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			cache_model.check_result({kind, status, key_out, value_out, last});
	end

	// Receiver stall pattern: stretches of random stall, stretches without, long hold-offs.
	initial begin
		int unsigned run;
		forever begin
			@(negedge clk);
			if (hold_off_cycles != 0) begin
				out_stall <= 1'b1;
				repeat (hold_off_cycles) @(negedge clk);
				hold_off_cycles = 0;
				out_stall <= 1'b0;
			end else if (random_stall) begin
				run = $urandom_range(1, 12);
				if ($urandom_range(0, 2) == 0) begin
					out_stall <= 1'b0;
					repeat (run) @(negedge clk);
				end else
					repeat (run) begin
						out_stall <= ($urandom_range(0, 2) == 0);
						@(negedge clk);
					end
				out_stall <= 1'b0;
			end else
				out_stall <= 1'b0;
		end
	end

	// Offers one request and holds it until it transfers; leaves the port idle afterwards.
	task automatic send_request(input logic [1:0] op, input logic [63:0] key,
			input logic [63:0] v);
		in_valid = 1'b1;
		opcode = op;
		key_tag = key;
		value_in = v;
		do
			@(posedge clk);
		while (in_stall);
		cache_model.note_request(op, key, v);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// Waits until every predicted result has arrived, then lets the core settle.
	task automatic drain();
		while (cache_model.pending.size() != 0)
			@(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	// Writes the capacity register; only called with the core idle.
	task automatic write_capacity(input logic [4:0] cap);
		cfg_valid = 1'b1;
		cfg_data = cap;
		do
			@(posedge clk);
		while (!cfg_ready);
		cache_model.capacity_reg = cap;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Keys with a random top byte, a low byte in 0..span and zeros between.
	function automatic logic [63:0] pool_key(int unsigned span);
		logic [63:0] k;
		k = {$urandom, $urandom};
		k[7:0] = 8'($urandom_range(0, span));
		return {k[63:56], 48'h0, k[7:0]};
	endfunction

	// Random phase: mostly get-then-fill sequences and sets, some flushes, stray fills and lone gets.
	task automatic random_phase(input int unsigned count, input int unsigned span);
		logic [63:0] key, v;
		int unsigned pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 19);
			key = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : pool_key(span);
			v = {$urandom, $urandom};
			if (pick < 8) begin
				send_request(cwbc_pkg::OP_GET, key, {$urandom, $urandom});
				// usually follow the get with a fill of the backing data, whether it hit or missed
				if ($urandom_range(0, 4) != 0)
					send_request(cwbc_pkg::OP_FILL, key, v);
				n++;
			end else if (pick < 15)
				send_request(cwbc_pkg::OP_SET, key, v);
			else if (pick < 17)
				send_request(cwbc_pkg::OP_FILL, key, v);
			else if (pick < 18)
				send_request(cwbc_pkg::OP_FLUSH, key, v);
			else
				send_request(cwbc_pkg::OP_GET, key, v);
			// sender bursts with random gaps
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 10)) @(negedge clk);
		end
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		repeat (4) @(negedge clk);

		// Directed: field extremes and every operation, at reset capacity.
		send_request(cwbc_pkg::OP_GET, 64'h0, 64'h0);
		send_request(cwbc_pkg::OP_FILL, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(cwbc_pkg::OP_GET, 64'h0, 64'h0);
		send_request(cwbc_pkg::OP_SET, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
		send_request(cwbc_pkg::OP_SET, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		// fill of a present key
		send_request(cwbc_pkg::OP_FILL, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1234);
		// fill with no miss before it
		send_request(cwbc_pkg::OP_FILL, 64'hA5A5_5A5A_0F0F_F0F0, 64'h5A5A_A5A5_F0F0_0F0F);
		send_request(cwbc_pkg::OP_FLUSH, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(cwbc_pkg::OP_FLUSH, 64'h0, 64'h0);
		drain();

		// Capacity 1: every new key evicts, dirty victims write back.
		write_capacity(5'd1);
		send_request(cwbc_pkg::OP_SET, 64'h11, 64'h1);
		send_request(cwbc_pkg::OP_SET, 64'h22, 64'h2);
		send_request(cwbc_pkg::OP_FILL, 64'h33, 64'h3);
		send_request(cwbc_pkg::OP_SET, 64'h44, 64'h4);
		drain();

		// Zero counts as one; out-of-range values clamp to sixteen.
		write_capacity(5'd0);
		send_request(cwbc_pkg::OP_SET, 64'h55, 64'h5);
		send_request(cwbc_pkg::OP_GET, 64'h22, 64'h0);
		drain();
		write_capacity(5'd31);
		send_request(cwbc_pkg::OP_FLUSH, 64'h77, 64'h0);
		drain();

		random_stall = 1;
		random_phase(90, 40);
		drain();

		// Lower the capacity below the fill count.
		write_capacity(5'd3);
		random_phase(60, 12);
		drain();

		write_capacity(5'd16);
		// Long receiver hold-off while requests keep coming, so the core backs up.
		hold_off_cycles = 400;
		random_phase(40, 30);
		drain();

		write_capacity(5'd7);
		random_phase(60, 20);
		// Sender pauses until the core has delivered everything.
		drain();
		write_capacity(5'd2);
		random_phase(40, 6);
		drain();
		write_capacity(5'd16);
		random_phase(40, 24);
		send_request(cwbc_pkg::OP_FLUSH, 64'h0, 64'h0);
		drain();

		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#4ms;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
`default_nettype wire
